// ===== design/pcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsd_pkg: shared constants, codes and pattern tables
// Sizes of the mode map, soft-value format, transaction codes and the
// per-mode puncture pattern lookups of the per-carrier depuncturer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsd_pkg;

  // Mode map depth and soft-value width
  localparam int NUM_CARRIERS = 256;
  localparam int SOFT_WIDTH   = 16;

  // Map address and active-count widths
  localparam int CAR_AW = (NUM_CARRIERS > 1) ? $clog2(NUM_CARRIERS) : 1;
  localparam int CNT_W  = $clog2(NUM_CARRIERS + 1);

  // Input field widths
  localparam int IDX_W  = 8;
  localparam int MODE_W = 4;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 4'd0;
  localparam logic [MODE_W-1:0] MODE_MAX    = 4'd9;

  typedef enum logic {
    OP_MAP_WRITE = 1'b0,
    OP_SOFT      = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_MODE   = 2'd1,
    ERR_NO_CARRIER = 2'd2
  } err_e;

  // Pattern length in slots; unused and unknown codes behave as mode 1
  function automatic logic [3:0] mode_len(input logic [MODE_W-1:0] mode);
    logic [3:0] len;
    case (mode)
      4'd3, 4'd5, 4'd7, 4'd9: len = 4'd6;
      4'd6:                   len = 4'd4;
      4'd8:                   len = 4'd10;
      default:                len = 4'd1;
    endcase
    return len;
  endfunction

  // Pattern periods per carrier
  function automatic logic [3:0] mode_reps(input logic [MODE_W-1:0] mode);
    logic [3:0] reps;
    case (mode)
      4'd2, 4'd6, 4'd9: reps = 4'd4;
      4'd3:             reps = 4'd1;
      4'd4:             reps = 4'd8;
      4'd7:             reps = 4'd3;
      default:          reps = 4'd2;
    endcase
    return reps;
  endfunction

  // Pattern mask: bit k set where slot k carries a received value
  function automatic logic [15:0] mode_pat(input logic [MODE_W-1:0] mode);
    logic [15:0] pat;
    case (mode)
      4'd3, 4'd5, 4'd7, 4'd9: pat = 16'b0000_0000_0001_1011;
      4'd6:                   pat = 16'b0000_0000_0000_1011;
      4'd8:                   pat = 16'b0000_0001_1001_1011;
      default:                pat = 16'b0000_0000_0000_0001;
    endcase
    return pat;
  endfunction

  // Count the punctured slots that follow slot pos, at most two
  function automatic logic [1:0] fill_count(input logic [MODE_W-1:0] mode,
                                            input logic [3:0] pos);
    logic [3:0]  len;
    logic [15:0] pat;
    logic [1:0]  cnt;
    logic        run;
    logic [3:0]  slot;
    len  = mode_len(mode);
    pat  = mode_pat(mode);
    cnt  = 2'd0;
    run  = 1'b1;
    slot = pos;
    for (int j = 1; j <= 2; j++) begin
      slot = pos + 4'(j);
      if (run && (slot < len) && !pat[slot]) begin
        cnt = cnt + 2'd1;
      end else begin
        run = 1'b0;
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ===== design/pcsd_if.sv =====
// ----------------------------------------------------------------------------
// pcsd_if: valid/ready channels of the per-carrier depuncturer
// Input channel carries map writes and soft values; output channel carries
// the depunctured result stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcsd_in_if import pcsd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [IDX_W-1:0]             carrier_index;
  logic [MODE_W-1:0]            carrier_mode;
  logic signed [SOFT_WIDTH-1:0] soft_in;

  modport source (
    output valid, operation, carrier_index, carrier_mode, soft_in,
    input  ready
  );
  modport sink (
    input  valid, operation, carrier_index, carrier_mode, soft_in,
    output ready
  );
endinterface

interface pcsd_out_if import pcsd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SOFT_WIDTH-1:0] soft_out;
  logic                         last_of_run;
  logic                         end_of_symbol;
  logic [1:0]                   error_code;

  modport source (
    output valid, soft_out, last_of_run, end_of_symbol, error_code,
    input  ready
  );
  modport sink (
    input  valid, soft_out, last_of_run, end_of_symbol, error_code,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/per_carrier_soft_depuncturer.sv =====
// ----------------------------------------------------------------------------
// per_carrier_soft_depuncturer: soft-value depuncturer driven by a mode map
// Walks a per-subcarrier mode map over incoming soft values and inserts the
// fill value at punctured pattern slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one transaction is a map write (operation 0: carrier_index,
//            carrier_mode) or one soft value (operation 1: soft_in).
//   out_if : one to three results per input transaction; last_of_run marks
//            the final one, end_of_symbol the last result of a map pass.
//   cfg    : cfg_we_i writes fill_value from cfg_data_i; write it while idle.
// Processing (one transaction in flight at a time):
//   map write: S_WR updates the entry, then S_EMIT registers the result.
//   soft value         : with no active carrier, S_EMIT registers an error
//                        result; else the map read, then S_LOOK steps past
//                        each unused carrier, plus, when a carrier completes,
//                        S_NEXT scans map entries to find the next active
//                        carrier (up to the end of the map), then S_EMIT loads each result in turn.
//   The mode memory gives one read per cycle, which sets the walk speed.
// Reset clears the map (per-entry valid bits), the walk position and
// fill_value. A stalled receiver holds the output register; the block keeps
// working until the next result needs the register, and in_if.ready is high
// whenever no transaction is being processed.
// ----------------------------------------------------------------------------
`default_nettype none

module per_carrier_soft_depuncturer import pcsd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [SOFT_WIDTH-1:0] cfg_data_i,
  pcsd_in_if.sink                    in_if,
  pcsd_out_if.source                 out_if
);

  localparam int CAR_EW = (CAR_AW > IDX_W) ? CAR_AW : IDX_W;
  localparam logic [CAR_AW-1:0] CAR_LAST = CAR_AW'(NUM_CARRIERS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_LOOK,
    S_NEXT,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  // Walk state
  logic [CAR_AW-1:0] ptr_q, ptr_d;
  logic [2:0]        rep_q, rep_d;
  logic [3:0]        pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic signed [SOFT_WIDTH-1:0] fill_q;

  // Held input transaction
  logic [IDX_W-1:0]             idx_q;
  logic [MODE_W-1:0]            mode_q;
  logic signed [SOFT_WIDTH-1:0] soft_q;

  // Pending results of the current transaction
  logic [1:0] n_q, n_d;
  logic [1:0] k_q, k_d;
  err_e       err_q, err_d;
  logic       eos_q, eos_d;
  logic       zero_q, zero_d;

  // Output register
  logic                         ov_q, ov_d;
  logic signed [SOFT_WIDTH-1:0] os_q, os_d;
  logic                         ol_q, ol_d;
  logic                         oe_q, oe_d;
  err_e                         oc_q, oc_d;

  // Mode memory and its valid bits
  logic [MODE_W-1:0]       mode_mem [NUM_CARRIERS];
  logic [NUM_CARRIERS-1:0] vld_q;
  logic [MODE_W-1:0]       rd_q;
  logic                    rdv_q;
  logic [CAR_AW-1:0]       mem_ra;
  logic                    mem_we;
  logic [CAR_AW-1:0]       mem_wa;
  logic [MODE_W-1:0]       rd_mode;

  logic              in_acc;
  logic [CAR_EW-1:0] in_idx_ext;
  logic [CAR_EW-1:0] q_idx_ext;
  logic [CAR_AW-1:0] in_addr;
  logic [CAR_AW-1:0] q_addr;
  logic              q_in_rng;
  logic [CAR_AW-1:0] ptr_nxt;

  // Lookup results for the current carrier
  logic [3:0] cur_len;
  logic [3:0] cur_pos;
  logic [1:0] cur_fill;
  logic [3:0] pos_after;
  logic [3:0] rep_inc;
  logic       last_res;

  assign in_acc     = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);

  assign in_idx_ext = CAR_EW'(in_if.carrier_index);
  assign q_idx_ext  = CAR_EW'(idx_q);
  assign in_addr    = in_idx_ext[CAR_AW-1:0];
  assign q_addr     = q_idx_ext[CAR_AW-1:0];
  assign q_in_rng   = (32'(idx_q) < 32'(NUM_CARRIERS));
  assign ptr_nxt    = (ptr_q == CAR_LAST) ? '0 : ptr_q + 1'b1;

  // Unwritten entries read as unused
  assign rd_mode = rdv_q ? rd_q : MODE_UNUSED;

  assign cur_len   = mode_len(rd_mode);
  assign cur_pos   = (pos_q >= cur_len) ? 4'd0 : pos_q;
  assign cur_fill  = fill_count(rd_mode, cur_pos);
  assign pos_after = cur_pos + 4'd1 + 4'(cur_fill);
  assign rep_inc   = 4'(rep_q) + 4'd1;
  assign last_res  = (k_q == n_q - 2'd1);

  assign mem_wa = q_addr;

  // Mode memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mode_mem[mem_wa] <= mode_q;
    end
    rd_q <= mode_mem[mem_ra];
  end

  // Valid bits: cleared by reset, set on first write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      rdv_q <= vld_q[mem_ra];
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q  <= in_if.carrier_index;
      mode_q <= in_if.carrier_mode;
      soft_q <= in_if.soft_in;
    end
  end

  // Fill value register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cfg_we_i) begin
      fill_q <= cfg_data_i;
    end
  end

  // Next state, walk update, memory control and result emission
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    rep_d   = rep_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    k_d     = k_q;
    err_d   = err_q;
    eos_d   = eos_q;
    zero_d  = zero_q;
    ov_d    = ov_q;
    os_d    = os_q;
    ol_d    = ol_q;
    oe_d    = oe_q;
    oc_d    = oc_q;
    mem_ra  = ptr_q;
    mem_we  = 1'b0;

    // Drop the output once the receiver takes it
    if (ov_q && out_if.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_if.operation == OP_MAP_WRITE) begin
          mem_ra = in_addr;
        end
        if (in_acc) begin
          k_d    = 2'd0;
          n_d    = 2'd1;
          eos_d  = 1'b0;
          zero_d = 1'b1;
          err_d  = ERR_NONE;
          if (in_if.operation == OP_MAP_WRITE) begin
            state_d = S_WR;
          end else if (cnt_q == '0) begin
            err_d   = ERR_NO_CARRIER;
            state_d = S_EMIT;
          end else begin
            state_d = S_LOOK;
          end
        end
      end

      S_WR: begin
        // Update the entry and the active count for a valid mode and an index in range; always restart the walk
        if (mode_q > MODE_MAX) begin
          err_d = ERR_BAD_MODE;
        end else if (q_in_rng) begin
          mem_we = 1'b1;
          if ((mode_q != MODE_UNUSED) && (rd_mode == MODE_UNUSED)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else if ((mode_q == MODE_UNUSED) && (rd_mode != MODE_UNUSED)) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        ptr_d   = '0;
        rep_d   = 3'd0;
        pos_d   = 4'd0;
        state_d = S_EMIT;
      end

      S_LOOK: begin
        if (rd_mode == MODE_UNUSED) begin
          // Skip an unused carrier, wrapping at the end of the map
          ptr_d  = ptr_nxt;
          mem_ra = ptr_nxt;
          rep_d  = 3'd0;
          pos_d  = 4'd0;
        end else begin
          n_d    = cur_fill + 2'd1;
          zero_d = 1'b0;
          state_d = S_EMIT;
          if (pos_after >= cur_len) begin
            pos_d = 4'd0;
            if (rep_inc >= mode_reps(rd_mode)) begin
              // Carrier done: look for the next active one
              rep_d = 3'd0;
              if (ptr_q == CAR_LAST) begin
                eos_d = 1'b1;
                ptr_d = '0;
              end else begin
                ptr_d   = ptr_nxt;
                mem_ra  = ptr_nxt;
                state_d = S_NEXT;
              end
            end else begin
              rep_d = rep_inc[2:0];
            end
          end else begin
            pos_d = pos_after;
          end
        end
      end

      S_NEXT: begin
        if (rd_mode != MODE_UNUSED) begin
          state_d = S_EMIT;
        end else if (ptr_q == CAR_LAST) begin
          eos_d   = 1'b1;
          ptr_d   = '0;
          state_d = S_EMIT;
        end else begin
          ptr_d  = ptr_nxt;
          mem_ra = ptr_nxt;
        end
      end

      S_EMIT: begin
        // Load one result whenever the output register is free
        if (!ov_q || out_if.ready) begin
          ov_d = 1'b1;
          if (zero_q) begin
            os_d = '0;
          end else if (k_q == 2'd0) begin
            os_d = soft_q;
          end else begin
            os_d = fill_q;
          end
          ol_d = last_res;
          oe_d = last_res && eos_q;
          oc_d = err_q;
          k_d  = k_q + 2'd1;
          if (last_res) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      rep_q   <= 3'd0;
      pos_q   <= 4'd0;
      cnt_q   <= '0;
      n_q     <= 2'd1;
      k_q     <= 2'd0;
      err_q   <= ERR_NONE;
      eos_q   <= 1'b0;
      zero_q  <= 1'b0;
      ov_q    <= 1'b0;
      os_q    <= '0;
      ol_q    <= 1'b0;
      oe_q    <= 1'b0;
      oc_q    <= ERR_NONE;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      rep_q   <= rep_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      k_q     <= k_d;
      err_q   <= err_d;
      eos_q   <= eos_d;
      zero_q  <= zero_d;
      ov_q    <= ov_d;
      os_q    <= os_d;
      ol_q    <= ol_d;
      oe_q    <= oe_d;
      oc_q    <= oc_d;
    end
  end

  assign out_if.valid         = ov_q;
  assign out_if.soft_out      = os_q;
  assign out_if.last_of_run   = ol_q;
  assign out_if.end_of_symbol = oe_q;
  assign out_if.error_code    = oc_q;

`ifndef SYNTHESIS
  // Active count never exceeds the map depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_CARRIERS))
    else $error("active carrier count out of range");

  // The carrier walk only runs when some carrier is active
  a_walk_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> (cnt_q != '0))
    else $error("carrier walk without an active carrier");

  // Result index stays within the result count of the transaction
  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ((k_q < n_q) && (n_q != 2'd0)))
    else $error("result index beyond result count");

  // A map entry is written only in the cycle after a map-write transaction
  a_write_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> $past(in_acc && (in_if.operation == OP_MAP_WRITE)))
    else $error("mode memory written without a map write");

  // End of symbol only marks the final, error-free result of a soft value
  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oe_q) |-> (ol_q && (oc_q == ERR_NONE)))
    else $error("end of symbol on a non-final or error result");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the per-carrier soft depuncturer
// Drives map writes and soft values through the input channel, keeps its own
// copy of the mode map and walk position to work out each expected result,
// and compares every output transaction in order. Both sides idle at random,
// the receiver holds off once for a long stretch, and fill_value is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
  import pcsd_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int SHOW_LIMIT  = 10;

  typedef struct {
    op_e                          op;
    logic [IDX_W-1:0]             idx;
    logic [MODE_W-1:0]            mode;
    logic signed [SOFT_WIDTH-1:0] sample;
  } in_item_t;

  typedef struct {
    logic signed [SOFT_WIDTH-1:0] value;
    logic                         last;
    logic                         eos;
    err_e                         err;
  } result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [SOFT_WIDTH-1:0] cfg_data_i;

  pcsd_in_if  in_ch ();
  pcsd_out_if out_ch ();

  per_carrier_soft_depuncturer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #4 clk_i = ~clk_i;

  // Stimulus and expectation stores
  in_item_t stim_q[$];
  result_t  expected_q[$];
  in_item_t tx_next;

  // Predictor state: mode map, walk position and fill level
  logic [MODE_W-1:0]     mode_map [NUM_CARRIERS];
  int                    walk_car;
  int                    walk_rep;
  int                    walk_pos;
  logic [SOFT_WIDTH-1:0] fill_level;

  // Generator view of which carriers are active
  bit gen_active [NUM_CARRIERS];
  int random_pushed;

  // Flow control and bookkeeping
  bit calm;
  bit in_took;
  bit rx_hold_req;
  int rx_hold_left;
  int n_accepted;
  int n_checked;
  int n_eos;
  int n_err_results;
  int n_bad;

  // Periods of the pattern per carrier
  function automatic int periods_of(input int m);
    case (m)
      2, 6, 9: return 4;
      3:       return 1;
      4:       return 8;
      7:       return 3;
      default: return 2;
    endcase
  endfunction

  // Slots in one period of the pattern
  function automatic int slots_of(input int m);
    case (m)
      3, 5, 7, 9: return 6;
      6:          return 4;
      8:          return 10;
      default:    return 1;
    endcase
  endfunction

  // Bit k set where slot k takes a received value
  function automatic logic [9:0] punct_mask(input int m);
    case (m)
      3, 5, 7, 9: return 10'b00_0001_1011;
      6:          return 10'b00_0000_1011;
      8:          return 10'b01_1001_1011;
      default:    return 10'b00_0000_0001;
    endcase
  endfunction

  function automatic int first_active(input int from);
    for (int c = from; c < NUM_CARRIERS; c++) begin
      if (mode_map[c] != MODE_UNUSED) return c;
    end
    return NUM_CARRIERS;
  endfunction

  // Work out the results of one accepted transaction and queue them
  task automatic depuncture(input in_item_t it);
    result_t    outs [3];
    int         c;
    int         m;
    int         pos;
    int         n;
    bit         eos;
    bit         empty;
    logic [9:0] mask;
    empty = 1'b0;
    if (it.op == OP_MAP_WRITE) begin
      outs[0] = '{value: '0, last: 1'b1, eos: 1'b0,
                  err: (it.mode > MODE_MAX) ? ERR_BAD_MODE : ERR_NONE};
      if (it.mode <= MODE_MAX) mode_map[it.idx] = it.mode;
      walk_car = 0;
      walk_rep = 0;
      walk_pos = 0;
      expected_q = {expected_q, outs[0]};
    end else begin
      c = (walk_car < NUM_CARRIERS) ? first_active(walk_car) : NUM_CARRIERS;
      if (c >= NUM_CARRIERS) begin
        c = first_active(0);
        if (c >= NUM_CARRIERS) begin
          empty = 1'b1;
        end else begin
          walk_rep = 0;
          walk_pos = 0;
        end
      end
      if (empty) begin
        // Drop the value: nothing is active
        outs[0] = '{value: '0, last: 1'b1, eos: 1'b0, err: ERR_NO_CARRIER};
        expected_q = {expected_q, outs[0]};
      end else begin
        if (c != walk_car) begin
          walk_rep = 0;
          walk_pos = 0;
        end
        walk_car = c;
        m    = int'(mode_map[c]);
        mask = punct_mask(m);
        pos  = (walk_pos >= slots_of(m)) ? 0 : walk_pos;
        outs[0] = '{value: it.sample, last: 1'b0, eos: 1'b0, err: ERR_NONE};
        n = 1;
        pos++;
        // Insert the fill value at each punctured slot after the value
        while (pos < slots_of(m) && !mask[pos] && n < 3) begin
          outs[n] = '{value: fill_level, last: 1'b0, eos: 1'b0, err: ERR_NONE};
          n++;
          pos++;
        end
        eos = 1'b0;
        if (pos >= slots_of(m)) begin
          pos = 0;
          walk_rep++;
          if (walk_rep >= periods_of(m)) begin
            walk_rep = 0;
            if (first_active(c + 1) >= NUM_CARRIERS) begin
              eos      = 1'b1;
              walk_car = 0;
            end else begin
              walk_car = c + 1;
            end
          end
        end
        walk_pos = pos;
        outs[n-1].last = 1'b1;
        outs[n-1].eos  = eos;
        for (int k = 0; k < n; k++) expected_q = {expected_q, outs[k]};
      end
    end
  endtask

  task automatic report(input string msg);
    n_bad++;
    if (n_bad <= SHOW_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // Queue one transaction; fields that the operation ignores carry noise
  task automatic push_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic [MODE_W-1:0] mode,
                           input logic [SOFT_WIDTH-1:0] sample);
    in_item_t it;
    it.op = op;
    if (op == OP_MAP_WRITE) begin
      it.idx    = idx;
      it.mode   = mode;
      it.sample = SOFT_WIDTH'($urandom);
      if (mode <= MODE_MAX) gen_active[idx] = (mode != MODE_UNUSED);
    end else begin
      it.idx    = IDX_W'($urandom);
      it.mode   = MODE_W'($urandom);
      it.sample = sample;
    end
    stim_q = {stim_q, it};
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 50) return IDX_W'($urandom_range(15));
    if (r < 80) return IDX_W'($urandom_range(255));
    return IDX_W'($urandom_range(255, 240));
  endfunction

  // Clear active carriers, each one with the given chance in percent
  task automatic clear_map(input int pct);
    for (int c = 0; c < NUM_CARRIERS; c++) begin
      if (gen_active[c] && $urandom_range(99) < pct) begin
        push_item(OP_MAP_WRITE, IDX_W'(c), MODE_UNUSED, '0);
        random_pushed++;
      end
    end
  endtask

  task automatic push_stream(input int count);
    for (int k = 0; k < count; k++) begin
      push_item(OP_SOFT, '0, '0, SOFT_WIDTH'($urandom));
      random_pushed++;
    end
  endtask

  // One random sequence: mostly a fresh small map then a soft-value stream
  task automatic random_burst();
    int kind;
    int ncar;
    kind = $urandom_range(99);
    if (kind < 70) begin
      clear_map(50);
      ncar = $urandom_range(3, 1);
      for (int k = 0; k < ncar; k++) begin
        push_item(OP_MAP_WRITE, pick_index(), MODE_W'($urandom_range(9, 1)), '0);
        random_pushed++;
      end
      push_stream($urandom_range(40, 8));
    end else if (kind < 85) begin
      // Rejected mode mid-stream: restarts the walk, map unchanged
      push_item(OP_MAP_WRITE, pick_index(), MODE_W'($urandom_range(15, 10)), '0);
      random_pushed++;
      push_stream($urandom_range(6, 1));
    end else begin
      clear_map(100);
      push_stream($urandom_range(3, 1));
    end
  endtask

  task automatic wait_idle();
    while (stim_q.size() != 0 || in_ch.valid || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_fill(input logic [SOFT_WIDTH-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    fill_level  = v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Record accepted input transactions and predict their results
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      depuncture('{op: op_e'(in_ch.operation), idx: in_ch.carrier_index,
                   mode: in_ch.carrier_mode, sample: in_ch.soft_in});
      n_accepted++;
    end
  end

  // Driver: hold the offer until taken, then advance or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (stim_q.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
        tx_next = stim_q.pop_front();
        in_ch.operation     <= tx_next.op;
        in_ch.carrier_index <= tx_next.idx;
        in_ch.carrier_mode  <= tx_next.mode;
        in_ch.soft_in       <= tx_next.sample;
        in_ch.valid         <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: value %0d last %0b eos %0b err %0d",
                         out_ch.soft_out, out_ch.last_of_run, out_ch.end_of_symbol,
                         out_ch.error_code));
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (exp_r.eos) n_eos++;
        if (exp_r.err != ERR_NONE) n_err_results++;
        if (out_ch.soft_out !== exp_r.value || out_ch.last_of_run !== exp_r.last ||
            out_ch.end_of_symbol !== exp_r.eos || out_ch.error_code !== exp_r.err) begin
          report($sformatf({"result %0d mismatch: got value %0d last %0b eos %0b ",
                            "err %0d, expected value %0d last %0b eos %0b err %0d"},
                           n_checked, out_ch.soft_out, out_ch.last_of_run,
                           out_ch.end_of_symbol, out_ch.error_code, exp_r.value,
                           exp_r.last, exp_r.eos, exp_r.err));
        end
      end
    end
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int base;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_data_i          = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_MAP_WRITE;
    in_ch.carrier_index = '0;
    in_ch.carrier_mode  = '0;
    in_ch.soft_in       = '0;
    out_ch.ready        = 1'b0;
    for (int c = 0; c < NUM_CARRIERS; c++) begin
      mode_map[c]   = MODE_UNUSED;
      gen_active[c] = 1'b0;
    end
    walk_car   = 0;
    walk_rep   = 0;
    walk_pos   = 0;
    fill_level = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty map, rejected modes, sparse map, widest pattern
    set_fill(16'h8000);
    push_item(OP_SOFT, '0, '0, 16'h7FFF);
    push_item(OP_MAP_WRITE, 8'd0, 4'd15, '0);
    push_item(OP_SOFT, '0, '0, 16'h8000);
    push_item(OP_MAP_WRITE, 8'd255, 4'd3, '0);
    push_item(OP_SOFT, '0, '0, 16'h7FFF);
    push_item(OP_SOFT, '0, '0, 16'h8000);
    push_item(OP_SOFT, '0, '0, 16'h0000);
    push_item(OP_SOFT, '0, '0, 16'hFFFF);
    push_item(OP_SOFT, '0, '0, 16'h0001);
    push_item(OP_MAP_WRITE, 8'd0, 4'd8, '0);
    push_item(OP_SOFT, '0, '0, 16'h5555);
    push_item(OP_SOFT, '0, '0, 16'hAAAA);
    for (int k = 1; k <= 4; k++) push_item(OP_SOFT, '0, '0, SOFT_WIDTH'(k));
    push_item(OP_MAP_WRITE, 8'd255, MODE_UNUSED, '0);
    push_item(OP_MAP_WRITE, 8'd128, 4'd6, '0);
    for (int k = 0; k < 4; k++) push_item(OP_SOFT, '0, '0, SOFT_WIDTH'($urandom));
    push_item(OP_MAP_WRITE, 8'd0, MODE_UNUSED, '0);
    push_item(OP_MAP_WRITE, 8'd128, MODE_UNUSED, '0);
    push_item(OP_SOFT, '0, '0, 16'h0064);
    wait_idle();

    // Random phase with no idling on either side
    set_fill(16'h7FFF);
    calm = 1'b1;
    while (random_pushed < 70) random_burst();
    wait_idle();
    calm = 1'b0;

    // Random phase with a long receiver hold-off while the sender keeps offering
    set_fill(SOFT_WIDTH'($urandom));
    while (random_pushed < 140) random_burst();
    base = n_accepted;
    while (n_accepted < base + 20 && stim_q.size() != 0) @(posedge clk_i);
    rx_hold_req = 1'b1;
    wait_idle();

    // Random phase with zero fill
    set_fill(16'h0000);
    while (random_pushed < 200) random_burst();
    wait_idle();

    // Let any stray result show up
    repeat (600) @(posedge clk_i);
    if (expected_q.size() != 0) report("results still expected at the end");
    $display("Covered %0d input transactions, %0d results checked, %0d symbol ends,",
             n_accepted, n_checked, n_eos);
    $display("%0d error results, %0d mismatches.", n_err_results, n_bad);
    if (n_bad == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== per_carrier_soft_depuncturer.f =====
design/pcsd_pkg.sv
design/pcsd_if.sv
design/per_carrier_soft_depuncturer.sv
dv/tb_top.sv
